// ===== sv/mrd_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus RTU request decoder.
`default_nettype none

package mrd_pkg;

    // Memory map and limits
    localparam int unsigned MAX_FRAME      = 256;
    localparam int unsigned DI_POINTS      = 4096;
    localparam int unsigned AI_POINTS      = 1024;
    localparam int unsigned COUNTER_SPAN   = 512;
    localparam int unsigned COIL_POINTS    = 1024;
    localparam int unsigned BUS_LINES      = 50;

    localparam int unsigned DI_BASE        = 10001;
    localparam int unsigned DS_BASE        = 20001;
    localparam int unsigned DS_TOP         = DS_BASE + 1000;
    localparam int unsigned AI_BASE        = 30001;
    localparam int unsigned CNT_BASE       = 36801;
    localparam int unsigned CNT_TOP        = CNT_BASE + 1024;
    localparam int unsigned BUS_BASE       = 50000;
    localparam int unsigned BUS_SPAN       = 2 * BUS_LINES;
    localparam int unsigned BUS_TOP        = BUS_BASE + BUS_SPAN;
    localparam int unsigned COIL_ADDR_END  = 10000;
    localparam int unsigned MAX_BIT_COUNT  = 1024;
    localparam int unsigned MAX_REG_COUNT  = 120;
    localparam int unsigned MAX_CNT_COUNT  = 127;
    localparam int unsigned MIN_FRAME      = 5;
    localparam int unsigned MIN_DATA_FRAME = 8;
    localparam int unsigned HDR_BYTES      = 6;

    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] COIL_ON_VALUE  = 16'hFF00;

    // Frame length counter saturates at MAX_FRAME + 1
    localparam int unsigned CNT_W = $clog2(MAX_FRAME + 2);

    // Function codes
    localparam logic [7:0] FC_READ_DI    = 8'h02;
    localparam logic [7:0] FC_READ_HOLD  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL = 8'h05;

    // Configuration register indexes
    localparam logic REG_DEVICE_ADDRESS     = 1'b0;
    localparam logic REG_DEVICE_STATE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        KIND_DROP,
        KIND_DISCRETE,
        KIND_DEVSTATE,
        KIND_ANALOG,
        KIND_COUNTER,
        KIND_BUS,
        KIND_COIL,
        KIND_EXCEPTION
    } req_kind_t;

    typedef enum logic [1:0] {
        EXC_NONE,
        EXC_FUNCTION,
        EXC_ADDRESS,
        EXC_DATA
    } exc_code_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } req_in_t;

    typedef struct packed {
        req_kind_t   request_kind;
        logic [7:0]  function_code;
        exc_code_t   exception_code;
        logic [13:0] point_offset;
        logic [10:0] point_count;
        logic        coil_on;
    } req_out_t;

    typedef struct packed {
        logic [7:0] device_address;
        logic [9:0] device_state_count;
    } dev_cfg_t;

    // Frame summary handed from the byte path to the decoder
    typedef struct packed {
        logic [CNT_W-1:0] frame_len;
        logic             crc_ok;
        logic [7:0]       addr_byte;
        logic [7:0]       func;
        logic [15:0]      start_addr;
        logic [15:0]      quantity;
    } frame_info_t;

    // Reflected CRC-16 update over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mrd_decode.sv =====
// Request decoder: checks a completed frame against the register map.
`default_nettype none

module mrd_decode (
    input  wire mrd_pkg::frame_info_t info,
    input  wire mrd_pkg::dev_cfg_t    cfg,
    output mrd_pkg::req_out_t         result
);
    import mrd_pkg::*;

    logic [15:0] a;
    logic [15:0] n;
    logic [7:0]  fc;
    logic [13:0] di_off, ds_off, ai_off, cnt_off, bus_off, coil_off;
    logic [16:0] di_end, ds_end, ai_end, cnt_end, bus_end;
    logic        n_bits_bad, n_regs_bad, n_cnt_bad, n_bus_bad;
    logic        frame_bad;

    assign a  = info.start_addr;
    assign n  = info.quantity;
    assign fc = info.func;

    // Offsets from each region base (only used inside that region)
    assign di_off   = 14'(a - 16'(DI_BASE));
    assign ds_off   = 14'(a - 16'(DS_BASE));
    assign ai_off   = 14'(a - 16'(AI_BASE));
    assign cnt_off  = 14'(a - 16'(CNT_BASE));
    assign bus_off  = 14'(a - 16'(BUS_BASE));
    assign coil_off = 14'(a - 16'd1);

    assign di_end  = {3'b000, di_off} + {1'b0, n};
    assign ds_end  = {3'b000, ds_off} + {1'b0, n};
    assign ai_end  = {3'b000, ai_off} + {1'b0, n};
    assign cnt_end = {3'b000, cnt_off} + {1'b0, n};
    assign bus_end = {3'b000, bus_off} + {1'b0, n};

    // Quantity limits per request type
    assign n_bits_bad = (n == 16'd0) || (n > 16'(MAX_BIT_COUNT));
    assign n_regs_bad = (n == 16'd0) || (n > 16'(MAX_REG_COUNT));
    assign n_cnt_bad  = (n == 16'd0) || (n > 16'(MAX_CNT_COUNT)) || n[0];
    assign n_bus_bad  = (n == 16'd0) || (n > 16'(BUS_SPAN)) || n[0];

    // Short, long, corrupt or foreign frames are dropped
    assign frame_bad = (info.frame_len < CNT_W'(MIN_FRAME))
                    || (info.frame_len > CNT_W'(MAX_FRAME))
                    || !info.crc_ok
                    || (info.addr_byte != cfg.device_address);

    always_comb begin
        result = '0;
        priority if (frame_bad) begin
            result = '0;
        end else if ((fc < FC_READ_DI) || (fc > FC_WRITE_COIL)) begin
            result.request_kind   = KIND_EXCEPTION;
            result.function_code  = fc;
            result.exception_code = EXC_FUNCTION;
        end else if (info.frame_len < CNT_W'(MIN_DATA_FRAME)) begin
            result = '0;
        end else begin
            unique case (fc)
                FC_READ_DI: begin
                    priority if ((a >= 16'(DI_BASE)) && (a < 16'(DS_BASE))) begin
                        result.function_code = fc;
                        priority if (n_bits_bad) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_DATA;
                        end else if (di_end > 17'(DI_POINTS)) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_ADDRESS;
                        end else begin
                            result.request_kind = KIND_DISCRETE;
                            result.point_offset = di_off;
                            result.point_count  = n[10:0];
                        end
                    end else if ((a >= 16'(DS_BASE)) && (a <= 16'(DS_TOP))) begin
                        result.function_code = fc;
                        priority if (a == 16'(DS_TOP)) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_ADDRESS;
                        end else if (n_bits_bad) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_DATA;
                        end else if (ds_end > {7'd0, cfg.device_state_count}) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_ADDRESS;
                        end else begin
                            result.request_kind = KIND_DEVSTATE;
                            result.point_offset = ds_off;
                            result.point_count  = n[10:0];
                        end
                    end else begin
                        result = '0;
                    end
                end
                FC_WRITE_COIL: begin
                    priority if ((a < 16'd1) || (a >= 16'(COIL_ADDR_END))) begin
                        result.request_kind   = KIND_EXCEPTION;
                        result.function_code  = fc;
                        result.exception_code = EXC_ADDRESS;
                    end else if (coil_off >= 14'(COIL_POINTS)) begin
                        result = '0;
                    end else if ((n == COIL_ON_VALUE) || (n == 16'd0)) begin
                        result.request_kind  = KIND_COIL;
                        result.function_code = fc;
                        result.point_offset  = coil_off;
                        result.point_count   = 11'd1;
                        result.coil_on       = (n == COIL_ON_VALUE);
                    end else begin
                        result.request_kind   = KIND_EXCEPTION;
                        result.function_code  = fc;
                        result.exception_code = EXC_DATA;
                    end
                end
                default: begin
                    // Register reads: analog, counter pairs, bus counters
                    priority if ((a >= 16'(AI_BASE)) && (a < 16'(CNT_BASE))) begin
                        result.function_code = fc;
                        priority if (n_regs_bad) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_DATA;
                        end else if (ai_end > 17'(AI_POINTS)) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_ADDRESS;
                        end else begin
                            result.request_kind = KIND_ANALOG;
                            result.point_offset = ai_off;
                            result.point_count  = n[10:0];
                        end
                    end else if ((a >= 16'(CNT_BASE)) && (a <= 16'(CNT_TOP))) begin
                        result.function_code = fc;
                        priority if (!a[0]) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_ADDRESS;
                        end else if (n_cnt_bad || (cnt_end > 17'(COUNTER_SPAN))) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_DATA;
                        end else begin
                            result.request_kind = KIND_COUNTER;
                            result.point_offset = cnt_off;
                            result.point_count  = n[10:0];
                        end
                    end else if ((a >= 16'(BUS_BASE)) && (a <= 16'(BUS_TOP))) begin
                        result.function_code = fc;
                        priority if (a[0]) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_ADDRESS;
                        end else if (n_bus_bad || (bus_end > 17'(BUS_SPAN))) begin
                            result.request_kind   = KIND_EXCEPTION;
                            result.exception_code = EXC_DATA;
                        end else begin
                            result.request_kind = KIND_BUS;
                            result.point_offset = bus_off;
                            result.point_count  = n[10:0];
                        end
                    end else begin
                        result = '0;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/modbus_rtu_request_decoder.sv =====
// Top level of the Modbus RTU request decoder: byte path, CRC, frame state and output register.
`default_nettype none

// Accepts one frame byte per clock cycle, back to back, with frame_end on the last
// byte of each request. Every byte is first captured in an input register; from
// there the CRC-16 byte update, the frame state update and, on the last byte, the
// request decode all complete in one pass and load the result register. Exactly
// one result transaction follows each frame_end byte (request_kind 0 for a dropped
// frame) and none follows other bytes. Input only stalls when a frame_end byte meets
// a result that has not yet been taken. Write device_address (index 0, reset 1) and
// device_state_count (index 1, reset 0) only while no frame is in flight.
module modbus_rtu_request_decoder (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mrd_pkg::req_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mrd_pkg::req_out_t      m_data,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [9:0]        cfg_wdata
);
    import mrd_pkg::*;

    logic             in_valid_reg;
    req_in_t          in_data_reg;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       delay0_reg, delay1_reg;
    logic [7:0]       hdr_reg [HDR_BYTES];
    logic [7:0]       hdr_next [HDR_BYTES];
    dev_cfg_t         cfg_reg;
    logic             m_valid_reg;
    req_out_t         m_data_reg;
    logic             advance;
    logic [7:0]       cur_byte;
    frame_info_t      info;
    req_out_t         dec_out;

    // Move the held byte on unless it ends a frame and the result slot is full and not taken
    assign advance = in_valid_reg && (!in_data_reg.frame_end || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign cur_byte = in_data_reg.rx_byte;

    // Capture the incoming byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // CRC runs two bytes behind so the trailing CRC bytes stay out of it
    assign crc_next = (byte_count_reg >= CNT_W'(2)) ? crc16_byte(crc_reg, delay0_reg) : crc_reg;
    assign byte_count_next = (byte_count_reg < CNT_W'(MAX_FRAME + 1))
                           ? byte_count_reg + CNT_W'(1) : byte_count_reg;

    // Header bytes as seen after this byte
    always_comb begin
        for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_next[i] = (byte_count_reg == CNT_W'(i)) ? cur_byte : hdr_reg[i];
        end
    end

    always_comb begin
        info.frame_len  = byte_count_next;
        info.crc_ok     = (crc_next[7:0] == delay1_reg) && (crc_next[15:8] == cur_byte);
        info.addr_byte  = hdr_next[0];
        info.func       = hdr_next[1];
        info.start_addr = {hdr_next[2], hdr_next[3]};
        info.quantity   = {hdr_next[4], hdr_next[5]};
    end

    mrd_decode u_decode (
        .info   (info),
        .cfg    (cfg_reg),
        .result (dec_out)
    );

    // Advance frame state; clear it after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            delay0_reg     <= '0;
            delay1_reg     <= '0;
        end else if (advance) begin
            if (in_data_reg.frame_end) begin
                byte_count_reg <= '0;
                crc_reg        <= CRC_INIT;
                delay0_reg     <= '0;
                delay1_reg     <= '0;
            end else begin
                byte_count_reg <= byte_count_next;
                crc_reg        <= crc_next;
                delay0_reg     <= delay1_reg;
                delay1_reg     <= cur_byte;
            end
        end
    end

    // Header bytes keep their value across frames
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < HDR_BYTES; i++) begin
                hdr_reg[i] <= hdr_next[i];
            end
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address     <= 8'd1;
            cfg_reg.device_state_count <= 10'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS:     cfg_reg.device_address     <= cfg_wdata[7:0];
                REG_DEVICE_STATE_COUNT: cfg_reg.device_state_count <= cfg_wdata;
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_data_reg.frame_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && in_data_reg.frame_end) begin
            m_data_reg <= dec_out;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A frame end always leaves the frame state cleared
    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.frame_end |=> (byte_count_reg == '0) && (crc_reg == CRC_INIT))
        else $error("frame state not cleared after frame end");

    // A frame end with a free slot always yields a result
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && in_data_reg.frame_end && !m_valid_reg |=> m_valid_reg)
        else $error("frame end produced no result");

    // Exception results carry a code, others none
    a_exc_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_data_reg.request_kind == KIND_EXCEPTION)
                         == (m_data_reg.exception_code != EXC_NONE)))
        else $error("exception code does not match request kind");

    // Dropped results are all zero
    a_drop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.request_kind == KIND_DROP) |-> (m_data_reg == '0))
        else $error("dropped result carries data");

    // Only coil writes set the coil action
    a_coil_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.coil_on |-> (m_data_reg.request_kind == KIND_COIL))
        else $error("coil action on a non-coil result");

endmodule

`default_nettype wire

// ===== test/modbus_request_checker.sv =====
// Checker for the Modbus RTU request decoder: watches both channels, predicts each reply, compares.
`timescale 1ns / 1ps

module modbus_request_checker (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic            s_ready,
    input  mrd_pkg::req_in_t     s_data,
    input  wire logic            m_valid,
    input  wire logic            m_ready,
    input  mrd_pkg::req_out_t    m_data,
    input  wire logic            cfg_wr_en,
    input  wire logic            cfg_index,
    input  wire logic [9:0]      cfg_wdata,
    output int unsigned          outstanding,
    output int unsigned          failures
);
    import mrd_pkg::*;

    // Shadow configuration
    logic [7:0]  own_address;
    logic [9:0]  state_bits;

    // Shadow frame state: length, running CRC, two-byte tail, first six bytes
    int unsigned frame_len;
    logic [15:0] crc_run;
    logic [7:0]  tail [2];
    logic [7:0]  head [HDR_BYTES];

    req_out_t    replies_q [$];
    int unsigned shown;

    // Bit-serial reflected CRC-16, least significant bit first
    function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
        logic fb;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ 16'hA001;
            end
        end
        return c;
    endfunction

    function automatic req_out_t reply(req_kind_t k, logic [7:0] fc, exc_code_t x,
                                       int unsigned off, int unsigned n, logic on);
        req_out_t r;
        r.request_kind   = k;
        r.function_code  = fc;
        r.exception_code = x;
        r.point_offset   = 14'(off);
        r.point_count    = 11'(n);
        r.coil_on        = on;
        return r;
    endfunction

    function automatic req_out_t refused(logic [7:0] fc, exc_code_t x);
        return reply(KIND_EXCEPTION, fc, x, 0, 0, 1'b0);
    endfunction

    // Work out the reply for the frame that just ended
    function automatic req_out_t decode_frame();
        req_out_t    dropped;
        logic [7:0]  fc;
        int unsigned a, n, off;
        dropped = '0;
        fc = head[1];
        if (frame_len < MIN_FRAME || frame_len > MAX_FRAME) return dropped;
        if (crc_run != {tail[1], tail[0]}) return dropped;
        if (head[0] != own_address) return dropped;
        if (fc < FC_READ_DI || fc > FC_WRITE_COIL) return refused(fc, EXC_FUNCTION);
        if (frame_len < MIN_DATA_FRAME) return dropped;
        a = {head[2], head[3]};
        n = {head[4], head[5]};

        if (fc == FC_READ_DI) begin
            if (a >= DI_BASE && a < DS_BASE) begin
                off = a - DI_BASE;
                if (n == 0 || n > MAX_BIT_COUNT) return refused(fc, EXC_DATA);
                if (off + n > DI_POINTS) return refused(fc, EXC_ADDRESS);
                return reply(KIND_DISCRETE, fc, EXC_NONE, off, n, 1'b0);
            end
            if (a >= DS_BASE && a <= DS_TOP) begin
                off = a - DS_BASE;
                if (a == DS_TOP) return refused(fc, EXC_ADDRESS);
                if (n == 0 || n > MAX_BIT_COUNT) return refused(fc, EXC_DATA);
                if (off + n > state_bits) return refused(fc, EXC_ADDRESS);
                return reply(KIND_DEVSTATE, fc, EXC_NONE, off, n, 1'b0);
            end
            return dropped;
        end

        if (fc == FC_WRITE_COIL) begin
            if (a < 1 || a >= COIL_ADDR_END) return refused(fc, EXC_ADDRESS);
            off = a - 1;
            if (off >= COIL_POINTS) return dropped;
            if (n == COIL_ON_VALUE) return reply(KIND_COIL, fc, EXC_NONE, off, 1, 1'b1);
            if (n == 0) return reply(KIND_COIL, fc, EXC_NONE, off, 1, 1'b0);
            return refused(fc, EXC_DATA);
        end

        // register reads, functions 03 and 04
        if (a >= AI_BASE && a < CNT_BASE) begin
            off = a - AI_BASE;
            if (n == 0 || n > MAX_REG_COUNT) return refused(fc, EXC_DATA);
            if (off + n > AI_POINTS) return refused(fc, EXC_ADDRESS);
            return reply(KIND_ANALOG, fc, EXC_NONE, off, n, 1'b0);
        end
        if (a >= CNT_BASE && a <= CNT_TOP) begin
            off = a - CNT_BASE;
            if (a[0] == 1'b0) return refused(fc, EXC_ADDRESS);
            if (n == 0 || n > MAX_CNT_COUNT || n[0]) return refused(fc, EXC_DATA);
            if (off + n > COUNTER_SPAN) return refused(fc, EXC_DATA);
            return reply(KIND_COUNTER, fc, EXC_NONE, off, n, 1'b0);
        end
        if (a >= BUS_BASE && a <= BUS_TOP) begin
            off = a - BUS_BASE;
            if (a[0]) return refused(fc, EXC_ADDRESS);
            if (n == 0 || n > BUS_SPAN || n[0]) return refused(fc, EXC_DATA);
            if (off + n > BUS_SPAN) return refused(fc, EXC_DATA);
            return reply(KIND_BUS, fc, EXC_NONE, off, n, 1'b0);
        end
        return dropped;
    endfunction

    function automatic void clear_frame();
        frame_len = 0;
        crc_run   = CRC_INIT;
        tail[0]   = 8'h00;
        tail[1]   = 8'h00;
    endfunction

    always @(posedge aclk) begin
        req_out_t want;
        if (!aresetn) begin
            own_address = 8'd1;
            state_bits  = 10'd0;
            clear_frame();
            replies_q.delete();
            shown    = 0;
            failures = 0;
        end else begin
            // track register writes
            if (cfg_wr_en) begin
                if (cfg_index == REG_DEVICE_ADDRESS) begin
                    own_address = cfg_wdata[7:0];
                end else begin
                    state_bits = cfg_wdata;
                end
            end

            // compare a delivered reply with the oldest prediction
            if (m_valid && m_ready) begin
                if (replies_q.size() == 0) begin
                    failures++;
                    if (shown < 10) begin
                        shown++;
                        $display("%0t: reply with none pending: kind=%0d fc=%02h exc=%0d",
                                 $realtime, m_data.request_kind, m_data.function_code,
                                 m_data.exception_code);
                    end
                end else begin
                    want = replies_q.pop_front();
                    if (m_data.request_kind !== want.request_kind ||
                        m_data.function_code !== want.function_code ||
                        m_data.exception_code !== want.exception_code ||
                        m_data.point_offset !== want.point_offset ||
                        m_data.point_count !== want.point_count ||
                        m_data.coil_on !== want.coil_on) begin
                        failures++;
                        if (shown < 10) begin
                            shown++;
                            $display("%0t: reply mismatch", $realtime);
                            $display("  want kind=%0d fc=%02h exc=%0d off=%0d cnt=%0d coil=%0b",
                                     want.request_kind, want.function_code,
                                     want.exception_code, want.point_offset,
                                     want.point_count, want.coil_on);
                            $display("  got  kind=%0d fc=%02h exc=%0d off=%0d cnt=%0d coil=%0b",
                                     m_data.request_kind, m_data.function_code,
                                     m_data.exception_code, m_data.point_offset,
                                     m_data.point_count, m_data.coil_on);
                        end
                    end
                end
            end

            // advance the shadow frame on each accepted byte
            if (s_valid && s_ready) begin
                if (frame_len < HDR_BYTES) begin
                    head[frame_len] = s_data.rx_byte;
                end
                if (frame_len >= 2) begin
                    crc_run = crc_step(crc_run, tail[0]);
                end
                tail[0] = tail[1];
                tail[1] = s_data.rx_byte;
                if (frame_len < MAX_FRAME + 1) begin
                    frame_len++;
                end
                if (s_data.frame_end) begin
                    replies_q = {replies_q, decode_frame()};
                    clear_frame();
                end
            end
        end
        outstanding = replies_q.size();
    end

endmodule

// ===== test/tb_modbus_rtu_request_decoder.sv =====
// Testbench top for the Modbus RTU request decoder: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tb_modbus_rtu_request_decoder;
    import mrd_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 540;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned LONG_STALL   = 300;

    typedef logic [7:0] octet_q_t [$];

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    req_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    req_out_t    m_data;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [9:0]  cfg_wdata;

    int unsigned outstanding;
    int unsigned failures;
    int unsigned items_sent;
    int unsigned burst_left;
    bit          stall_request;
    logic [7:0]  own_addr;

    modbus_rtu_request_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    modbus_request_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .failures    (failures)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("[modbus_rtu_request_decoder] ERROR");
        $finish;
    end

    // Frame CRC, appended low byte first
    function automatic logic [15:0] frame_crc(octet_q_t body);
        logic [15:0] c;
        c = CRC_INIT;
        foreach (body[i]) begin
            c = c ^ {8'h00, body[i]};
            repeat (8) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    function automatic octet_q_t sealed(octet_q_t body);
        logic [15:0] c;
        c = frame_crc(body);
        body = {body, c[7:0], c[15:8]};
        return body;
    endfunction

    function automatic octet_q_t request_body(logic [7:0] ad, logic [7:0] fc,
                                              logic [15:0] a, logic [15:0] n);
        octet_q_t q;
        q = {ad, fc, a[15:8], a[7:0], n[15:8], n[7:0]};
        return q;
    endfunction

    // Start address aimed at the map regions of the given function
    function automatic logic [15:0] pick_start(logic [7:0] fc);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        case (fc)
            FC_READ_DI: begin
                if (r < 6) return 16'(DI_BASE + $urandom_range(0, 4200));
                if (r == 6) return 16'(DS_BASE - 1 - $urandom_range(0, 60));
                return 16'(DS_BASE + $urandom_range(0, 1000));
            end
            FC_WRITE_COIL: begin
                if (r < 8) return 16'($urandom_range(0, 1100));
                return 16'($urandom_range(0, 10010));
            end
            default: begin
                if (r < 4) return 16'(AI_BASE + $urandom_range(0, 1100));
                if (r == 4) return 16'(AI_BASE + $urandom_range(0, 6799));
                if (r < 8) return 16'(CNT_BASE + $urandom_range(0, 1024));
                return 16'(BUS_BASE + $urandom_range(0, 100));
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_qty(logic [7:0] fc);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        case (fc)
            FC_WRITE_COIL: return (r < 5) ? COIL_ON_VALUE : ((r < 9) ? 16'h0000 : 16'($urandom));
            FC_READ_DI:    return 16'((r < 8) ? $urandom_range(1, 64) : $urandom_range(0, 1100));
            default: begin
                if (r < 6) return 16'(2 * $urandom_range(1, 60));
                if (r < 8) return 16'($urandom_range(1, 127));
                return 16'($urandom_range(0, 130));
            end
        endcase
    endfunction

    // Offer one byte; the sender runs in bursts with random gaps between them
    task automatic send_byte(logic [7:0] b, logic last);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_valid          = 1'b1;
        s_data.rx_byte   = b;
        s_data.frame_end = last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(octet_q_t f);
        foreach (f[i]) begin
            send_byte(f[i], i == f.size() - 1);
        end
    endtask

    task automatic send_req(int unsigned ad, int unsigned fc, int unsigned a, int unsigned n);
        send_frame(sealed(request_body(8'(ad), 8'(fc), 16'(a), 16'(n))));
    endtask

    // Hold the sender until every predicted reply has come back
    task automatic drain();
        s_valid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic apply_config(logic [7:0] ad, logic [9:0] cnt);
        own_addr = ad;
        write_reg(REG_DEVICE_ADDRESS, {2'b00, ad});
        write_reg(REG_DEVICE_STATE_COUNT, cnt);
    endtask

    // One random frame: mostly well-formed requests, the rest broken or noise
    task automatic send_random_frame();
        octet_q_t    f;
        int unsigned r, k;
        logic [7:0]  fc;
        r  = $urandom_range(0, 99);
        fc = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(2, 5));
        if (r < 82) begin
            f = request_body((r >= 70 && r < 76) ? 8'($urandom) : own_addr, fc,
                             pick_start(fc), pick_qty(fc));
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) f = {f, 8'($urandom)};
            end
            f = sealed(f);
            // corrupt one byte
            if (r >= 76) begin
                k = $urandom_range(0, f.size() - 1);
                f[k] = f[k] ^ 8'($urandom_range(1, 255));
            end
        end else if (r < 88) begin
            case ($urandom_range(0, 3))
                0:       fc = 8'hFF;
                1:       fc = 8'($urandom_range(0, 1));
                default: fc = 8'($urandom_range(6, 255));
            endcase
            f = request_body(own_addr, fc, 16'($urandom), 16'($urandom));
            f = f[0:$urandom_range(1, 5)];
            f = sealed(f);
        end else if (r < 94) begin
            // sealed but shorter than a data request
            f = request_body(own_addr, fc, 16'($urandom), 16'($urandom));
            f = f[0:$urandom_range(0, 4)];
            f = sealed(f);
        end else begin
            repeat ($urandom_range(1, 12)) f = {f, 8'($urandom)};
        end
        send_frame(f);
    endtask

    // Result side stalls on its own pattern, with one long hold-off on request
    initial begin
        int unsigned seg, pct;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (stall_request) begin
                m_ready = 1'b0;
                repeat (LONG_STALL) @(negedge aclk);
                stall_request = 1'b0;
            end
            case ($urandom_range(0, 3))
                0:       pct = 100;
                1:       pct = 70;
                2:       pct = 20;
                default: pct = 50;
            endcase
            seg = $urandom_range(8, 80);
            repeat (seg) begin
                @(negedge aclk);
                m_ready = ($urandom_range(1, 100) <= pct);
            end
        end
    end

    initial begin
        octet_q_t    f;
        int unsigned target;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_DEVICE_ADDRESS;
        cfg_wdata     = '0;
        items_sent    = 0;
        burst_left    = 0;
        stall_request = 1'b0;
        own_addr      = 8'd1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed requests under the reset configuration
        send_req(1, FC_READ_DI, DI_BASE, 1);
        send_req(1, FC_READ_DI, DI_BASE + 3072, MAX_BIT_COUNT);
        send_req(1, FC_READ_DI, DS_BASE - 1, 1);
        send_req(1, FC_READ_DI, DI_BASE, 0);
        send_req(1, FC_READ_DI, DI_BASE, MAX_BIT_COUNT + 1);
        send_req(1, FC_READ_DI, DS_BASE, 1);
        send_req(1, FC_READ_HOLD, AI_BASE, MAX_REG_COUNT);
        send_req(1, FC_READ_INPUT, AI_BASE + 1023, 1);
        send_req(1, FC_READ_INPUT, CNT_BASE - 1, 1);
        send_req(1, FC_READ_HOLD, AI_BASE, MAX_REG_COUNT + 1);
        send_req(1, FC_READ_HOLD, CNT_BASE, 2);
        send_req(1, FC_READ_HOLD, CNT_BASE + 1, 2);
        send_req(1, FC_READ_INPUT, CNT_BASE + 510, 2);
        send_req(1, FC_READ_INPUT, CNT_BASE, 3);
        send_req(1, FC_READ_INPUT, CNT_TOP, 2);
        send_req(1, FC_READ_HOLD, BUS_BASE, BUS_SPAN);
        send_req(1, FC_READ_INPUT, BUS_BASE + 1, 2);
        send_req(1, FC_READ_HOLD, BUS_TOP - 2, 4);
        send_req(1, FC_READ_HOLD, BUS_BASE, 0);
        send_req(1, FC_READ_HOLD, 16'hFFFF, 16'hFFFF);
        send_req(1, FC_WRITE_COIL, 1, COIL_ON_VALUE);
        send_req(1, FC_WRITE_COIL, COIL_POINTS, 0);
        send_req(1, FC_WRITE_COIL, COIL_POINTS + 1, COIL_ON_VALUE);
        send_req(1, FC_WRITE_COIL, 0, 0);
        send_req(1, FC_WRITE_COIL, COIL_ADDR_END, 0);
        send_req(1, FC_WRITE_COIL, 9, 16'h1234);
        send_req(1, 8'hFF, 16'h0000, 16'h0000);
        send_req(8'hFE, FC_READ_HOLD, AI_BASE, 1);

        // Minimum-length frame with an unknown function, then short data frames and frames below the minimum length
        f = request_body(8'd1, 8'hFF, 16'hA5A5, 16'd0);
        f = f[0:2];
        send_frame(sealed(f));
        f = request_body(8'd1, FC_READ_HOLD, 16'(AI_BASE), 16'd1);
        f = f[0:2];
        send_frame(sealed(f));
        f = request_body(8'd1, FC_WRITE_COIL, 16'd1, COIL_ON_VALUE);
        f = f[0:4];
        send_frame(sealed(f));
        f = request_body(8'd1, 8'h00, 16'd0, 16'd0);
        f = f[0:1];
        send_frame(sealed(f));
        f = {8'h01};
        send_frame(f);

        // Damaged CRC
        f = sealed(request_body(8'd1, FC_READ_HOLD, 16'(AI_BASE), 16'd1));
        f[7] = f[7] ^ 8'h80;
        send_frame(f);

        // Longest accepted frame, then one byte over
        f = request_body(8'd1, FC_READ_HOLD, 16'(AI_BASE + 5), 16'd7);
        while (f.size() < MAX_FRAME - 2) f = {f, 8'($urandom)};
        send_frame(sealed(f));
        f = {f, 8'($urandom)};
        send_frame(sealed(f));

        // Device-state region with the widest setting
        drain();
        apply_config(8'hFF, 10'd1000);
        send_req(8'hFF, FC_READ_DI, DS_BASE, 1000);
        send_req(8'hFF, FC_READ_DI, DS_TOP - 1, 1);
        send_req(8'hFF, FC_READ_DI, DS_TOP - 1, 2);
        send_req(8'hFF, FC_READ_DI, DS_TOP, 1);
        send_req(8'hFF, FC_READ_DI, DS_BASE, 0);
        send_req(8'h01, FC_READ_DI, DS_BASE, 1);

        // Random phases, each under its own configuration
        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0:       apply_config(8'($urandom), 10'd1000);
                1:       apply_config(8'h00, 10'd0);
                2:       apply_config(8'hFF, 10'($urandom_range(0, 1000)));
                4:       apply_config(8'($urandom), 10'd1000);
                default: apply_config(8'($urandom), 10'($urandom_range(0, 1000)));
            endcase
            // receiver holds off while requests keep coming
            if (p == 2) stall_request = 1'b1;
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target || (p == 2 && stall_request)) send_random_frame();
        end

        drain();
        repeat (8) @(negedge aclk);
        if (failures == 0) begin
            $display("[modbus_rtu_request_decoder] OK");
        end else begin
            $display("[modbus_rtu_request_decoder] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mrd_pkg.sv
sv/mrd_decode.sv
sv/modbus_rtu_request_decoder.sv
test/modbus_request_checker.sv
test/tb_modbus_rtu_request_decoder.sv
